// ===== src/trrwn_pkg.sv =====
// Package for the round robin thread scheduler.
// Holds the slot count, field widths, command, status and slot state codes,
// and the structs passed between the top level and the wait list.
package trrwn_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int KEY_W = 32;

	typedef enum logic [2:0] {
		CMD_CREATE = 3'd0,
		CMD_YIELD  = 3'd1,
		CMD_EXIT   = 3'd2,
		CMD_WAIT   = 3'd3,
		CMD_NOTIFY = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TABLE_FULL = 3'd1,
		ST_WAIT_FULL  = 3'd2,
		ST_NONE_RUN   = 3'd3,
		ST_NO_WAITER  = 3'd4,
		ST_NO_THREADS = 3'd5
	} status_t;

	localparam logic [1:0] SLOT_DEAD = 2'd0;
	localparam logic [1:0] SLOT_ALIVE = 2'd1;
	localparam logic [1:0] SLOT_SLEEP = 2'd2;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_PUSH
	} fsm_t;

	typedef struct packed {
		logic append;
		logic remove;
	} wl_ctl_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] slot;
	} wl_stat_t;

endpackage

// ===== src/trrwn_wcell.sv =====
// One entry of the wait list: a condition key and a slot index.
// Loads a new entry, or takes the entry of its upper neighbor on removal.
// Depends on trrwn_pkg.
module trrwn_wcell (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        shift,
	input  logic [trrwn_pkg::KEY_W-1:0] new_key,
	input  logic [trrwn_pkg::IDX_W-1:0] new_slot,
	input  logic [trrwn_pkg::KEY_W-1:0] nb_key,
	input  logic [trrwn_pkg::IDX_W-1:0] nb_slot,
	output logic [trrwn_pkg::KEY_W-1:0] key,
	output logic [trrwn_pkg::IDX_W-1:0] slot
);
	import trrwn_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (load) begin
			key_q  <= new_key;
			slot_q <= new_slot;
		end else if (shift) begin
			key_q  <= nb_key;
			slot_q <= nb_slot;
		end
	end

	assign key  = key_q;
	assign slot = slot_q;

endmodule

// ===== src/trrwn_wlist.sv =====
// Wait list built as a row of trrwn_wcell entries.
// Finds the last matching waiter and closes the gap on removal.
// Depends on trrwn_pkg and trrwn_wcell.
module trrwn_wlist (
	input  logic                        clk,
	input  trrwn_pkg::wl_ctl_t          ctl,
	input  logic [trrwn_pkg::CNT_W-1:0] count,
	input  logic [trrwn_pkg::KEY_W-1:0] key_in,
	input  logic [trrwn_pkg::IDX_W-1:0] slot_in,
	input  logic                        target_given,
	input  logic [trrwn_pkg::IDX_W-1:0] target_slot,
	output trrwn_pkg::wl_stat_t         stat
);
	import trrwn_pkg::*;

	logic [KEY_W-1:0] key_c [SLOTS];
	logic [IDX_W-1:0] slot_c [SLOTS];
	logic [SLOTS-1:0] match;
	logic [IDX_W-1:0] hit;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		localparam logic [CNT_W-1:0] POS = CNT_W'(i);
		localparam int NB = (i == SLOTS - 1) ? i : i + 1;
		logic load_i;
		logic shift_i;

		assign load_i  = ctl.append && (count == POS);
		assign shift_i = ctl.remove && (IDX_W'(i) >= hit) && ((POS + 1'b1) < count);
		assign match[i] = (POS < count) && (key_c[i] == key_in) &&
			(!target_given || slot_c[i] == target_slot);

		trrwn_wcell u_cell (
			.clk      (clk),
			.load     (load_i),
			.shift    (shift_i),
			.new_key  (key_in),
			.new_slot (slot_in),
			.nb_key   (key_c[NB]),
			.nb_slot  (slot_c[NB]),
			.key      (key_c[i]),
			.slot     (slot_c[i])
		);
	end

	always_comb begin
		hit = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match[i]) begin
				hit = IDX_W'(i);
			end
		end
	end

	assign stat.found = |match;
	assign stat.slot  = slot_c[hit];

endmodule

// ===== src/thread_round_robin_wait_notify.sv =====
// Top level of the round robin thread scheduler with condition waits.
// Holds the slot table and the sequencer; uses trrwn_wlist and trrwn_pkg.
//
// Usage: one command item enters on the s_ group and one result item leaves
// on the m_ group for every command. Create, notify, unknown commands and
// the error cases are finished in the cycle the item is accepted, so their
// result appears in the next cycle. Yield, exit and wait then walk the used
// slots round robin, one slot a cycle, looking for an alive thread; such an
// item's walk is bounded by the slot count before its result is pushed.
// One item is worked on at a time. The result sits in an output register;
// while the receiver stalls it holds and no new item is taken once a second
// result would have nowhere to go. Reset empties the slot table and the wait
// list and makes slot 0 current, with no result pending.
module thread_round_robin_wait_notify (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // cond_key[31:0], target_slot[35:32], zero pad
	input  logic [3:0]  s_tuser,  // command[2:0], target_given[3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // current_slot[3:0], created_slot[7:4]
	output logic [2:0]  m_tuser   // status[2:0]
);
	import trrwn_pkg::*;

	fsm_t fsm_q, fsm_d;
	logic [1:0]       sstate_q [SLOTS];
	logic [CNT_W-1:0] scount_q;
	logic [CNT_W-1:0] wcount_q;
	logic [IDX_W-1:0] run_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] n_q;
	logic             ov_q;
	logic [IDX_W-1:0] ocur_q, ocre_q;
	status_t          ostat_q, pstat_q;

	logic             accept, out_free, scan_hit, scan_end;
	logic [2:0]       command;
	logic [KEY_W-1:0] cond_key;
	logic [IDX_W-1:0] target_slot, next_pos;
	logic             no_thr, imm_done, start_scan;
	status_t          imm_stat;
	logic [IDX_W-1:0] imm_cre;
	wl_ctl_t          wctl;
	wl_stat_t         wstat;
	logic             wake_ok;

	assign command     = s_tuser[2:0];
	assign cond_key    = s_tdata[31:0];
	assign target_slot = s_tdata[35:32];
	assign out_free    = !ov_q || m_tready;
	assign accept      = s_tvalid && s_tready;
	assign no_thr      = (scount_q == '0);
	assign next_pos    = ((CNT_W'(pos_q) + 1'b1) == scount_q) ? '0 : pos_q + 1'b1;
	assign scan_hit    = (sstate_q[pos_q] == SLOT_ALIVE);
	assign scan_end    = ((n_q + 1'b1) == scount_q);
	assign wake_ok     = (CNT_W'(wstat.slot) < scount_q) && (sstate_q[wstat.slot] == SLOT_SLEEP);

	always_comb begin
		imm_done   = 1'b1;
		start_scan = 1'b0;
		imm_stat   = ST_OK;
		imm_cre    = '0;
		wctl       = '0;
		unique case (command)
			CMD_CREATE: begin
				if (scount_q == CNT_W'(SLOTS)) begin
					imm_stat = ST_TABLE_FULL;
				end else begin
					imm_cre = scount_q[IDX_W-1:0];
				end
			end
			CMD_YIELD, CMD_EXIT: begin
				if (no_thr) begin
					imm_stat = ST_NO_THREADS;
				end else begin
					imm_done   = 1'b0;
					start_scan = 1'b1;
				end
			end
			CMD_WAIT: begin
				if (no_thr) begin
					imm_stat = ST_NO_THREADS;
				end else if (wcount_q == CNT_W'(SLOTS)) begin
					imm_stat = ST_WAIT_FULL;
				end else begin
					imm_done    = 1'b0;
					start_scan  = 1'b1;
					wctl.append = accept;
				end
			end
			CMD_NOTIFY: begin
				wctl.remove = accept && wstat.found;
				imm_stat = (wstat.found && wake_ok) ? ST_OK : ST_NO_WAITER;
			end
			default: begin
			end
		endcase
	end

	trrwn_wlist u_wlist (
		.clk          (clk),
		.ctl          (wctl),
		.count        (wcount_q),
		.key_in       (cond_key),
		.slot_in      (run_q),
		.target_given (s_tuser[3]),
		.target_slot  (target_slot),
		.stat         (wstat)
	);

	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			FSM_IDLE: if (accept && start_scan) fsm_d = FSM_SCAN;
			FSM_SCAN: if (scan_hit || scan_end) fsm_d = FSM_PUSH;
			FSM_PUSH: if (out_free) fsm_d = FSM_IDLE;
			default:  fsm_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (fsm_q == FSM_IDLE) && out_free;
		m_tvalid = ov_q;
		m_tdata  = {ocre_q, ocur_q};
		m_tuser  = ostat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= FSM_IDLE;
			scount_q <= '0;
			wcount_q <= '0;
			run_q    <= '0;
			ov_q     <= 1'b0;
			pos_q    <= '0;
			n_q      <= '0;
			pstat_q  <= ST_OK;
			for (int i = 0; i < SLOTS; i++) sstate_q[i] <= SLOT_DEAD;
		end else begin
			fsm_q <= fsm_d;
			if ((accept && imm_done) || (fsm_q == FSM_PUSH && out_free)) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			if (accept) begin
				if (command == CMD_CREATE && scount_q != CNT_W'(SLOTS)) begin
					sstate_q[scount_q[IDX_W-1:0]] <= SLOT_ALIVE;
					scount_q <= scount_q + 1'b1;
				end
				if (start_scan && command == CMD_EXIT) sstate_q[run_q] <= SLOT_DEAD;
				if (start_scan && command == CMD_WAIT) begin
					sstate_q[run_q] <= SLOT_SLEEP;
					wcount_q <= wcount_q + 1'b1;
				end
				if (wctl.remove) begin
					wcount_q <= wcount_q - 1'b1;
					if (wake_ok) begin
						run_q <= wstat.slot;
						sstate_q[wstat.slot] <= SLOT_ALIVE;
					end
				end
				if (start_scan) begin
					pos_q <= ((CNT_W'(run_q) + 1'b1) == scount_q) ? '0 : run_q + 1'b1;
					n_q   <= '0;
				end
				if (imm_done) begin
					ocur_q  <= (wctl.remove && wake_ok) ? wstat.slot : run_q;
					ocre_q  <= imm_cre;
					ostat_q <= imm_stat;
				end
			end
			if (fsm_q == FSM_SCAN) begin
				if (scan_hit) begin
					run_q   <= pos_q;
					pstat_q <= ST_OK;
				end else if (scan_end) begin
					pstat_q <= ST_NONE_RUN;
				end else begin
					pos_q <= next_pos;
					n_q   <= n_q + 1'b1;
				end
			end
			if (fsm_q == FSM_PUSH && out_free) begin
				ocur_q  <= run_q;
				ocre_q  <= '0;
				ostat_q <= pstat_q;
			end
		end
	end

endmodule

// ===== src/trrwn_checker.sv =====
// Port checker for the round robin thread scheduler, bound to the top level.
// Depends on trrwn_pkg for the status codes.
module trrwn_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser
);
	import trrwn_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_created: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:4] != 4'd0 |-> m_tuser == ST_OK)
		else $error("created slot given with an error status");

	a_nothr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_NO_THREADS |-> m_tdata[3:0] == 4'd0)
		else $error("current slot moved with no threads");

endmodule

bind thread_round_robin_wait_notify trrwn_port_checks u_trrwn_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
